// ----- hw/rtl/integer_to_radix_digits_top_defines.svh -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top_defines
// Assertion macros shared by the radix conversion RTL.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_TOP_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ITR_ASSERT_NOW(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("%m: assertion failed");

// next-cycle implication
`define ITR_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("%m: assertion failed");

`else

`define ITR_ASSERT_NOW(label, clk, rstn, pre, post)
`define ITR_ASSERT_NEXT(label, clk, rstn, pre, post)

`endif

`endif

// ----- hw/rtl/itr_pkg.sv -----
// ----------------------------------------------------------------------------
// itr_pkg
// Shared constants, command type and digit glyph lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itr_pkg;

    localparam int VALUE_MAX_W         = 64;
    localparam int RADIX_W             = 6;
    localparam int CHAR_W              = 7;
    localparam int DIGIT_W             = 6;
    localparam int MAX_DIGITS          = 64;
    localparam int DIGIT_IDX_W         = $clog2(MAX_DIGITS);
    localparam int DIGIT_CNT_W         = DIGIT_IDX_W + 1;
    localparam int DEFAULT_VALUE_WIDTH = 64;
    localparam int BITS_PER_CYCLE      = 8;
    localparam int CMD_FIFO_DEPTH      = 2;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 6'd10;
    localparam logic [DIGIT_W-1:0] GLYPH_COUNT = 6'd36;

    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    typedef struct packed {
        logic                   err;
        logic                   neg;
        logic [RADIX_W-1:0]     radix;
        logic [VALUE_MAX_W-1:0] mag;
    } cmd_t;

    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] g;
        if (d < DEC_DIGITS) begin
            g = CHAR_ZERO + {1'b0, d};
        end else if (d < GLYPH_COUNT) begin
            g = CHAR_ALPHA + {1'b0, d} - {1'b0, DEC_DIGITS};
        end else begin
            g = CHAR_ZERO;
        end
        return g;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/integer_to_radix_digits_top.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top
// Integer to ASCII digit string converter, radix 2 to 36.
// ----------------------------------------------------------------------------
// Input channel (s_*): one transaction carries a value, a signed/unsigned mode
// and a radix. Output channel (m_*): one transaction per character, most
// significant digit first, a leading minus for negative signed values, m_last
// on the final character. A bad radix or the most negative signed value gives
// a single transaction with m_error and m_last set and a zero character.
// Items pass the classifier register and the command queue. For n digits,
// each digit then takes one division by the radix, eight quotient bits per
// cycle in the shared divider, and each digit character takes a digit
// memory read plus an output load. Error items leave without division.
// The queue lets new items be classified while a conversion runs.
// Reset (aresetn low, synchronous) empties the queue and the output register.
// While m_ready is low the current character is held and the engine waits
// before its next output load; a running division goes on meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_digits_top #(
    parameter int VALUE_WIDTH = itr_pkg::DEFAULT_VALUE_WIDTH,
    parameter int CMD_DEPTH   = itr_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [itr_pkg::VALUE_MAX_W-1:0]    s_value_bits,
    input  wire logic                               s_signed_mode,
    input  wire logic [itr_pkg::RADIX_W-1:0]        s_radix,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [itr_pkg::CHAR_W-1:0]              m_character,
    output logic                                    m_last,
    output logic                                    m_error
);

    logic           push_valid;
    logic           push_ready;
    itr_pkg::cmd_t  push_data;
    logic           pop_valid;
    logic           pop_ready;
    itr_pkg::cmd_t  pop_data;

    itr_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value_bits (s_value_bits),
        .s_signed_mode(s_signed_mode),
        .s_radix      (s_radix),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    itr_cmd_fifo #(
        .DEPTH(CMD_DEPTH)
    ) u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data)
    );

    itr_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_character(m_character),
        .m_last     (m_last),
        .m_error    (m_error)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/itr_front.sv -----
// ----------------------------------------------------------------------------
// itr_front
// Takes input transactions, checks radix and sign, forms the magnitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itr_front #(
    parameter int VALUE_WIDTH = itr_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [itr_pkg::VALUE_MAX_W-1:0]    s_value_bits,
    input  wire logic                               s_signed_mode,
    input  wire logic [itr_pkg::RADIX_W-1:0]        s_radix,
    output logic                                    push_valid,
    input  wire logic                               push_ready,
    output itr_pkg::cmd_t                           push_data
);

    localparam int VW = itr_pkg::VALUE_MAX_W;
    localparam logic [VW-1:0] MASK    = {VW{1'b1}} >> (VW - VALUE_WIDTH);
    localparam logic [VW-1:0] MIN_NEG = {{(VW-1){1'b0}}, 1'b1} << (VALUE_WIDTH - 1);

    logic           cmd_valid_reg;
    itr_pkg::cmd_t  cmd_reg;
    itr_pkg::cmd_t  cmd_next;
    logic [VW-1:0]  val;
    logic           radix_bad;
    logic           is_neg;

    always_comb begin
        val       = s_value_bits & MASK;
        radix_bad = (s_radix < itr_pkg::RADIX_MIN) || (s_radix > itr_pkg::RADIX_MAX);
        is_neg    = s_signed_mode & val[VALUE_WIDTH-1];
        cmd_next.err   = radix_bad || (s_signed_mode && (val == MIN_NEG));
        cmd_next.neg   = is_neg;
        cmd_next.radix = s_radix;
        cmd_next.mag   = is_neg ? ((~val + {{(VW-1){1'b0}}, 1'b1}) & MASK) : val;
    end

    assign s_ready    = !cmd_valid_reg || push_ready;
    assign push_valid = cmd_valid_reg;
    assign push_data  = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else if (s_ready) begin
            cmd_valid_reg <= s_valid;
            if (s_valid) begin
                cmd_reg <= cmd_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/itr_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// itr_cmd_fifo
// Short command queue between the classifier and the conversion engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itr_cmd_fifo #(
    parameter int DEPTH = itr_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  itr_pkg::cmd_t       push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output itr_pkg::cmd_t       pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    itr_pkg::cmd_t      entries [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/itr_back.sv -----
// ----------------------------------------------------------------------------
// itr_back
// Conversion engine: repeated division by the radix, then digit emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "integer_to_radix_digits_top_defines.svh"

module itr_back #(
    parameter int VALUE_WIDTH = itr_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           pop_valid,
    output logic                                pop_ready,
    input  itr_pkg::cmd_t                       pop_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [itr_pkg::CHAR_W-1:0]          m_character,
    output logic                                m_last,
    output logic                                m_error
);

    localparam int BPC        = itr_pkg::BITS_PER_CYCLE;
    localparam int PAD_W      = ((VALUE_WIDTH + BPC - 1) / BPC) * BPC;
    localparam int DIV_CYCLES = PAD_W / BPC;
    localparam int STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int DW         = itr_pkg::DIGIT_W;
    localparam int IDX_W      = itr_pkg::DIGIT_IDX_W;
    localparam int CNT_W      = itr_pkg::DIGIT_CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_RD,
        ST_PUT
    } state_t;

    state_t                         state_reg;
    logic [PAD_W-1:0]               quo_reg;
    logic [DW-1:0]                  rem_reg;
    logic [STEP_W-1:0]              step_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [IDX_W-1:0]               rd_idx_reg;
    logic                           neg_reg;
    logic [itr_pkg::RADIX_W-1:0]    radix_reg;
    logic                           m_valid_reg;
    logic [itr_pkg::CHAR_W-1:0]     m_character_reg;
    logic                           m_last_reg;
    logic                           m_error_reg;

    logic [DW-1:0]                  digit_store [itr_pkg::MAX_DIGITS];
    logic [DW-1:0]                  mem_rdata_reg;

    logic [PAD_W-1:0]               div_quo;
    logic [DW-1:0]                  div_rem;
    logic [PAD_W-1:0]               mag_pad;
    logic                           step_last;
    logic                           out_free;
    logic                           out_load;
    logic                           mem_we;

    // restoring division, BPC quotient bits per cycle
    always_comb begin
        logic [DW:0] trial;
        div_quo = quo_reg;
        div_rem = rem_reg;
        for (int i = 0; i < BPC; i++) begin
            trial   = {div_rem, div_quo[PAD_W-1]};
            div_quo = {div_quo[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, radix_reg}) begin
                trial      = trial - {1'b0, radix_reg};
                div_quo[0] = 1'b1;
            end
            div_rem = trial[DW-1:0];
        end
    end

    assign mag_pad   = PAD_W'(pop_data.mag[VALUE_WIDTH-1:0]);
    assign step_last = (step_reg == STEP_W'(DIV_CYCLES - 1));
    assign out_free  = !m_valid_reg || m_ready;
    assign mem_we    = (state_reg == ST_DIV) && step_last;
    assign pop_ready = (state_reg == ST_IDLE) && pop_valid && (!pop_data.err || out_free);

    // a new character transaction enters the output register this cycle
    assign out_load = out_free && (((state_reg == ST_IDLE) && pop_valid && pop_data.err)
                                   || (state_reg == ST_SIGN) || (state_reg == ST_PUT));

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;
    assign m_error     = m_error_reg;

    // digits land least significant first, read back from the top index down
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            digit_store[cnt_reg[IDX_W-1:0]] <= div_rem;
        end
        mem_rdata_reg <= digit_store[rd_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            quo_reg     <= '0;
        end else begin
            m_valid_reg <= out_load || (m_valid_reg && !m_ready);
            case (state_reg)
                ST_IDLE: begin
                    if (pop_valid) begin
                        if (pop_data.err) begin
                            if (out_free) begin
                                m_character_reg <= itr_pkg::CHAR_NONE;
                                m_last_reg      <= 1'b1;
                                m_error_reg     <= 1'b1;
                            end
                        end else begin
                            quo_reg   <= mag_pad;
                            rem_reg   <= '0;
                            step_reg  <= '0;
                            cnt_reg   <= '0;
                            neg_reg   <= pop_data.neg;
                            radix_reg <= pop_data.radix;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    quo_reg <= div_quo;
                    if (step_last) begin
                        cnt_reg  <= cnt_reg + 1'b1;
                        rem_reg  <= '0;
                        step_reg <= '0;
                        if (div_quo == '0) begin
                            rd_idx_reg <= cnt_reg[IDX_W-1:0];
                            state_reg  <= neg_reg ? ST_SIGN : ST_RD;
                        end
                    end else begin
                        rem_reg  <= div_rem;
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_SIGN: begin
                    if (out_free) begin
                        m_character_reg <= itr_pkg::CHAR_MINUS;
                        m_last_reg      <= 1'b0;
                        m_error_reg     <= 1'b0;
                        state_reg       <= ST_RD;
                    end
                end
                ST_RD: begin
                    // read data registered at the end of this cycle
                    state_reg <= ST_PUT;
                end
                ST_PUT: begin
                    if (out_free) begin
                        m_character_reg <= itr_pkg::digit_glyph(mem_rdata_reg);
                        m_last_reg      <= (rd_idx_reg == '0);
                        m_error_reg     <= 1'b0;
                        if (rd_idx_reg == '0) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            rd_idx_reg <= rd_idx_reg - 1'b1;
                            state_reg  <= ST_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ITR_ASSERT_NOW(a_err_single, aclk, aresetn, m_valid_reg && m_error_reg,
        m_last_reg && (m_character_reg == itr_pkg::CHAR_NONE))
    `ITR_ASSERT_NOW(a_rem_below_radix, aclk, aresetn, state_reg == ST_DIV,
        rem_reg < radix_reg)
    `ITR_ASSERT_NOW(a_cnt_bound, aclk, aresetn, 1'b1,
        cnt_reg <= CNT_W'(itr_pkg::MAX_DIGITS))
    `ITR_ASSERT_NOW(a_rd_in_range, aclk, aresetn,
        (state_reg == ST_RD) || (state_reg == ST_PUT), {1'b0, rd_idx_reg} < cnt_reg)
    `ITR_ASSERT_NEXT(a_rd_then_put, aclk, aresetn, state_reg == ST_RD,
        state_reg == ST_PUT)

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for integer_to_radix_digits_top.
// Values go in over the s_ channel. A built-in digit predictor builds the
// expected character run for each accepted value. A monitor checks every
// character transaction on the m_ channel in order against that run. Both
// sides idle at random, with stretches that have no idling at all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int          CYCLE_LIMIT   = 2_000_000;
    localparam int          RANDOM_ITEMS  = 400;
    localparam int          SETTLE_CYCLES = 700;
    localparam int          DIGIT_SLOTS   = itr_pkg::MAX_DIGITS;
    localparam logic [63:0] ALL_ONES      = ~64'd0;
    localparam logic [63:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POSITIVE = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [5:0]  RADIX_ZERO    = 6'd0;
    localparam logic [5:0]  RADIX_ONE     = 6'd1;
    localparam logic [5:0]  RADIX_OVER    = 6'd37;
    localparam logic [5:0]  RADIX_TOP     = 6'd63;
    localparam logic [0:35][7:0] GLYPHS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

    typedef struct packed {
        logic [63:0] value_bits;
        logic        signed_mode;
        logic [5:0]  radix;
        logic        drain_first;   // hold off until every pending character is out
    } digit_request_t;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
        logic       error;
    } char_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_value_bits = '0;
    logic        s_signed_mode = 1'b0;
    logic [5:0]  s_radix = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [6:0]  m_character;
    logic        m_last;
    logic        m_error;

    digit_request_t pending_requests[$];
    char_result_t   expected_chars[$];
    digit_request_t current_req;

    // predictor state
    logic [5:0]  digit_store [DIGIT_SLOTS];
    logic [63:0] quotient_left = '0;
    logic [6:0]  digits_held = '0;

    int unsigned cycle_count = 0;
    int unsigned request_total = 0;
    int unsigned accepted_count = 0;
    int unsigned due_count = 0;
    int unsigned seen_count = 0;
    int unsigned due_now;
    int unsigned rejected_total = 0;
    int unsigned negative_total = 0;
    int unsigned fail_count = 0;
    int          run_len;
    logic        calm;

    integer_to_radix_digits_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value_bits  (s_value_bits),
        .s_signed_mode (s_signed_mode),
        .s_radix       (s_radix),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_character   (m_character),
        .m_last        (m_last),
        .m_error       (m_error)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // no idling at all in the first part of each repeating window
    assign calm = (cycle_count % 40000) < 9000;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // builds the character run for one value, returns how many characters it has
    function automatic int predict_run(input digit_request_t req);
        logic [63:0]  base;
        logic         negative;
        int           n;
        int           produced;
        char_result_t r;
        base = 64'(req.radix);
        if (req.radix < itr_pkg::RADIX_MIN || req.radix > itr_pkg::RADIX_MAX
            || (req.signed_mode && req.value_bits == MOST_NEGATIVE)) begin
            r = '{character: itr_pkg::CHAR_NONE, last: 1'b1, error: 1'b1};
            expected_chars.push_back(r);
            rejected_total++;
            return 1;
        end
        negative = req.signed_mode && req.value_bits[63];
        quotient_left = negative ? (~req.value_bits + 64'd1) : req.value_bits;
        n = 0;
        if (quotient_left == 0) begin
            digit_store[0] = '0;
            n = 1;
        end else begin
            while (quotient_left != 0 && n < DIGIT_SLOTS) begin
                digit_store[n] = 6'(quotient_left % base);
                quotient_left = quotient_left / base;
                n++;
            end
        end
        digits_held = 7'(n);
        produced = 0;
        if (negative) begin
            r = '{character: itr_pkg::CHAR_MINUS, last: 1'b0, error: 1'b0};
            expected_chars.push_back(r);
            produced++;
            negative_total++;
        end
        for (int i = n - 1; i >= 0; i--) begin
            r = '{character: GLYPHS[digit_store[i]][6:0], last: (i == 0), error: 1'b0};
            expected_chars.push_back(r);
            produced++;
        end
        return produced;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            due_now = due_count;
            if (s_valid && s_ready) begin
                run_len = predict_run(current_req);
                due_now = due_count + run_len;
                due_count <= due_now;
                accepted_count <= accepted_count + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() != 0
                    && (calm || $urandom_range(0, 99) >= 9)
                    && (!pending_requests[0].drain_first || due_now == seen_count)) begin
                    current_req = pending_requests.pop_front();
                    s_value_bits  <= current_req.value_bits;
                    s_signed_mode <= current_req.signed_mode;
                    s_radix       <= current_req.radix;
                    s_valid       <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 9);
    end

    // monitor
    always @(posedge aclk) begin
        char_result_t want;
        if (aresetn && m_valid && m_ready) begin
            seen_count <= seen_count + 1;
            if (expected_chars.size() == 0) begin
                $error("character transaction with none expected: character=%0h last=%0b error=%0b",
                       m_character, m_last, m_error);
                fail_count++;
            end else begin
                want = expected_chars.pop_front();
                if (m_character !== want.character) begin
                    $error("character: expected %0h, actual %0h", want.character, m_character);
                    fail_count++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, m_last);
                    fail_count++;
                end
                if (m_error !== want.error) begin
                    $error("error: expected %0b, actual %0b", want.error, m_error);
                    fail_count++;
                end
            end
        end
    end

    task automatic add_request(input logic [63:0] value, input logic sgn,
                               input logic [5:0] radix, input logic drain);
        digit_request_t req;
        req = '{value_bits: value, signed_mode: sgn, radix: radix, drain_first: drain};
        pending_requests.push_back(req);
        request_total++;
    endtask

    initial begin
        logic [63:0] value;
        logic [63:0] width_mask;
        logic [5:0]  radix;
        logic        sgn;
        int          pick;
        int          bits;

        // directed: zero, extremes, bad radix codes, most negative value
        add_request(64'd0,          1'b0, 6'd10,              1'b0);
        add_request(64'd0,          1'b1, itr_pkg::RADIX_MIN, 1'b0);
        add_request(ALL_ONES,       1'b0, itr_pkg::RADIX_MIN, 1'b0);
        add_request(ALL_ONES,       1'b1, 6'd10,              1'b1);
        add_request(MOST_NEGATIVE,  1'b1, 6'd10,              1'b0);
        add_request(MOST_NEGATIVE,  1'b0, 6'd16,              1'b0);
        add_request(MOST_NEGATIVE,  1'b1, RADIX_ZERO,         1'b0);
        add_request(MOST_POSITIVE,  1'b1, itr_pkg::RADIX_MAX, 1'b0);
        add_request(MOST_POSITIVE,  1'b0, itr_pkg::RADIX_MIN, 1'b0);
        add_request(ALL_ONES,       1'b0, itr_pkg::RADIX_MAX, 1'b0);
        add_request(ALL_ONES,       1'b0, 6'd3,               1'b0);
        add_request(ALL_ONES,       1'b0, 6'd16,              1'b0);
        add_request(64'd12345,      1'b0, RADIX_ZERO,         1'b0);
        add_request(64'd12345,      1'b1, RADIX_ONE,          1'b0);
        add_request(ALL_ONES,       1'b0, RADIX_OVER,         1'b0);
        add_request(ALL_ONES,       1'b1, RADIX_TOP,          1'b0);
        add_request(64'd35,         1'b0, itr_pkg::RADIX_MAX, 1'b0);
        add_request(-64'sd255,      1'b1, 6'd16,              1'b0);
        add_request(-64'sd255,      1'b0, 6'd8,               1'b0);
        add_request(64'd0,          1'b1, itr_pkg::RADIX_MAX, 1'b0);
        add_request(MOST_NEGATIVE + 64'd1, 1'b1, itr_pkg::RADIX_MIN, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            sgn = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                radix = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 1))
                                                     : 6'($urandom_range(37, 63));
            end else if (pick < 30) begin
                case ($urandom_range(0, 4))
                    0:       radix = itr_pkg::RADIX_MIN;
                    1:       radix = 6'd8;
                    2:       radix = 6'd10;
                    3:       radix = 6'd16;
                    default: radix = itr_pkg::RADIX_MAX;
                endcase
            end else begin
                radix = 6'($urandom_range(2, 36));
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                value = 64'($urandom_range(0, 40));
            end else if (pick == 1) begin
                case ($urandom_range(0, 3))
                    0:       value = 64'd0;
                    1:       value = ALL_ONES;
                    2:       value = MOST_NEGATIVE;
                    default: value = MOST_POSITIVE;
                endcase
            end else if (pick < 5) begin
                value = {$urandom, $urandom};
            end else begin
                // narrow magnitudes keep most runs short
                bits = $urandom_range(1, 64);
                width_mask = (bits == 64) ? ALL_ONES : ((64'd1 << bits) - 64'd1);
                value = {$urandom, $urandom} & width_mask;
                if (sgn && $urandom_range(0, 1) == 1) begin
                    value = ~value + 64'd1;
                end
            end
            add_request(value, sgn, radix, (i % 97) == 96);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(accepted_count == request_total && due_count == seen_count)) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (expected_chars.size() != 0) begin
            $error("%0d expected characters never arrived", expected_chars.size());
            fail_count++;
        end
        $display("converted %0d values over radix 0..63: %0d rejected, %0d negative",
                 accepted_count, rejected_total, negative_total);
        $display("checked %0d character transactions in %0d cycles", seen_count, cycle_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
